[rtl/core/assert_macros.svh]
// Assertion macros shared by the weekly alarm matcher RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed in %m");

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition in %m");

`endif

[rtl/core/wdram_pkg.sv]
// Package for the weekly date range alarm matcher: constants, types and match functions.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package wdram_pkg;

	// Alarm storage and the number of alarms that are checked.
	localparam int ALARM_SLOTS = 8;
	localparam int NUM_ALARMS  = 8;
	localparam int IDX_W       = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 45;

	// Field widths of a tick.
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int WDAY_W   = 3;
	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int PRESET_W = 8;

	// Special values.
	localparam logic [HOUR_W-1:0]   EVERY_HOUR  = 5'd24;
	localparam logic [DAY_W-1:0]    LAST_DAY    = 5'd31;
	localparam logic [MINUTE_W-1:0] MINUTE_NONE = 6'd63;
	localparam int                  ENABLE_BIT  = 0;

	// Match vector queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Packed alarm register, most significant field first.
	typedef struct packed {
		logic [DAY_W-1:0]    end_day;
		logic [DAY_W-1:0]    start_day;
		logic [MONTH_W-1:0]  end_month;
		logic [MONTH_W-1:0]  start_month;
		logic [MINUTE_W-1:0] minute;
		logic [HOUR_W-1:0]   hour;
		logic [7:0]          wday_mask;
		logic [PRESET_W-1:0] preset;
	} alarm_t;

	typedef logic [ALARM_SLOTS-1:0]               match_vec_t;
	typedef logic [ALARM_SLOTS-1:0][PRESET_W-1:0] preset_vec_t;

	// One beat into the queue.
	typedef struct packed {
		logic       valid;
		match_vec_t vec;
	} match_beat_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

	// True when the date lies inside the alarm's month/day range.
	function automatic logic date_in_range(
		input logic [MONTH_W-1:0] ms,
		input logic [MONTH_W-1:0] me_raw,
		input logic [DAY_W-1:0]   ds,
		input logic [DAY_W-1:0]   de_raw,
		input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0]   d
	);
		logic [MONTH_W-1:0] me;
		logic [DAY_W-1:0]   de;
		logic               span;
		logic               r;
		me = (me_raw == '0) ? ms : me_raw;
		de = (de_raw == '0) ? LAST_DAY : de_raw;
		span = (ms < me) ? ((m > ms) && (m < me)) : ((m > ms) || (m < me));
		if ((ms == '0) || (ds == '0)) begin
			r = 1'b1;
		end else if (ms != me) begin
			if (span) begin
				r = 1'b1;
			end else if (m == ms) begin
				r = (d >= ds);
			end else if (m == me) begin
				r = (d <= de);
			end else begin
				r = 1'b0;
			end
		end else if (de < ds) begin
			// Whole year except the days strictly between end and start.
			r = (m != ms) || (d <= de) || (d >= ds);
		end else begin
			r = (m == ms) && (d >= ds) && (d <= de);
		end
		return r;
	endfunction

	// True when one alarm fires for the given tick.
	function automatic logic alarm_matches(
		input alarm_t              a,
		input logic [HOUR_W-1:0]   hr,
		input logic [MINUTE_W-1:0] mn,
		input logic [WDAY_W-1:0]   dow,
		input logic [DAY_W-1:0]    dom,
		input logic [MONTH_W-1:0]  mon
	);
		logic ok;
		ok = (a.preset != '0) && a.wday_mask[ENABLE_BIT] &&
			((a.hour == hr) || (a.hour == EVERY_HOUR)) && (a.minute == mn) &&
			(dow != '0) && a.wday_mask[dow];
		return ok && date_in_range(a.start_month, a.end_month, a.start_day, a.end_day,
			mon, dom);
	endfunction

	// Index of the lowest set bit; zero for an empty vector.
	function automatic logic [IDX_W-1:0] lowest_set(input match_vec_t v);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

[rtl/core/wdram_front.sv]
// Front of the alarm matcher: alarm registers, minute change detection and match vector.
// Depends on wdram_pkg; feeds wdram_queue.
`timescale 1ns / 1ps

module wdram_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [wdram_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wdram_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             push,
	input  wdram_pkg::q_stat_t               q_stat,
	input  logic [wdram_pkg::HOUR_W-1:0]     local_hour,
	input  logic [wdram_pkg::MINUTE_W-1:0]   local_minute,
	input  logic [wdram_pkg::WDAY_W-1:0]     day_of_week,
	input  logic [wdram_pkg::DAY_W-1:0]      day_of_month,
	input  logic [wdram_pkg::MONTH_W-1:0]    month_of_year,
	output wdram_pkg::match_beat_t           enq,
	output wdram_pkg::preset_vec_t           presets
);
	import wdram_pkg::*;

	alarm_t              alarm_q [ALARM_SLOTS];
	logic [MINUTE_W-1:0] prev_min_q;
	logic                accept;
	logic                new_min;
	match_vec_t          match;

	// Alarm register writes; indexes past the last slot are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALARM_SLOTS; i++) begin
				alarm_q[i] <= '0;
			end
		end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(ALARM_SLOTS))) begin
			alarm_q[cfg_index[IDX_W-1:0]] <= alarm_t'(cfg_wdata);
		end
	end

	assign accept  = push && !q_stat.full;
	assign new_min = (local_minute != prev_min_q);

	// Last minute seen; a tick with the same minute is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_min_q <= MINUTE_NONE;
		end else if (accept) begin
			prev_min_q <= local_minute;
		end
	end

	// All alarms are checked side by side.
	always_comb begin
		for (int i = 0; i < ALARM_SLOTS; i++) begin
			match[i] = (i < NUM_ALARMS) && alarm_matches(alarm_q[i], local_hour,
				local_minute, day_of_week, day_of_month, month_of_year);
			presets[i] = alarm_q[i].preset;
		end
	end

	// Only ticks that fire at least one alarm enter the queue.
	assign enq.valid = accept && new_min && (match != '0);
	assign enq.vec   = match;

endmodule

[rtl/core/wdram_queue.sv]
// Short queue of match vectors between the front and the back of the alarm matcher.
// Depends on wdram_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wdram_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wdram_pkg::match_beat_t enq,
	input  logic                   deq,
	output wdram_pkg::match_vec_t  head,
	output wdram_pkg::q_stat_t     stat
);
	import wdram_pkg::*;

	match_vec_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Storage entries carry no reset.
	always_ff @(posedge clk) begin
		if (enq.valid) begin
			mem_q[wr_ptr_q] <= enq.vec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(enq.valid) - QCNT_W'(deq);
		end
	end

	assign head          = mem_q[rd_ptr_q];
	assign stat.full     = (count_q == QCNT_W'(QDEPTH));
	assign stat.nonempty = (count_q != '0);

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, enq.valid && stat.full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, deq && !stat.nonempty)
	`ASSERT_AT(a_count_bound, clk, arst_n, count_q <= QCNT_W'(QDEPTH))

endmodule

[rtl/core/wdram_back.sv]
// Back of the alarm matcher: turns each match vector into result beats in index order.
// Depends on wdram_pkg and assert_macros.svh; reads from wdram_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wdram_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wdram_pkg::match_vec_t           head,
	input  wdram_pkg::q_stat_t              q_stat,
	input  wdram_pkg::preset_vec_t          presets,
	input  logic                            pop,
	output logic                            deq,
	output logic                            empty,
	output logic [wdram_pkg::PRESET_W-1:0]  preset_id,
	output logic [wdram_pkg::IDX_W-1:0]     alarm_index,
	output logic                            last_fire
);
	import wdram_pkg::*;

	match_vec_t          cur_q;
	logic                out_valid_q;
	logic [PRESET_W-1:0] out_preset_q;
	logic [IDX_W-1:0]    out_index_q;
	logic                out_last_q;
	logic                take;
	logic                has;
	logic                fire;
	logic                need_next;
	logic [IDX_W-1:0]    pick;
	match_vec_t          rest;
	match_vec_t          done_mask;

	// Output slot is free or being emptied this cycle.
	assign take = !out_valid_q || pop;
	assign has  = (cur_q != '0);
	assign fire = take && has;
	assign pick = lowest_set(cur_q);
	assign rest = cur_q & (cur_q - match_vec_t'(1));

	// Pull the next vector as soon as the current one is used up.
	assign need_next = !has || (fire && (rest == '0));
	assign deq       = need_next && q_stat.nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (deq) begin
				cur_q <= head;
			end else if (fire) begin
				cur_q <= rest;
			end
			if (take) begin
				out_valid_q <= fire;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (fire) begin
			out_preset_q <= presets[pick];
			out_index_q  <= pick;
			out_last_q   <= (rest == '0);
		end
	end

	assign empty       = !out_valid_q;
	assign preset_id   = out_preset_q;
	assign alarm_index = out_index_q;
	assign last_fire   = out_last_q;

	// Alarms at or below the shown index are already done.
	always_comb begin
		for (int i = 0; i < ALARM_SLOTS; i++) begin
			done_mask[i] = (IDX_W'(i) <= out_index_q);
		end
	end

	`ASSERT_AT(a_more_follow, clk, arst_n, out_valid_q && !out_last_q |-> has)
	`ASSERT_AT(a_index_order, clk, arst_n,
		out_valid_q && !out_last_q |-> (cur_q & done_mask) == '0)
	`ASSERT_AT(a_drain_after_last, clk, arst_n,
		out_valid_q && out_last_q && pop && !has |=> !out_valid_q)

endmodule

[rtl/core/weekly_date_range_alarm_matcher.sv]
// Top level of the weekly date range alarm matcher.
// Depends on wdram_pkg, wdram_front, wdram_queue and wdram_back.
`timescale 1ns / 1ps

// Usage:
// Time ticks enter through a queue-like port: a tick is taken at a rising edge
// with push high and full low. Results leave through a queue-like port: the
// oldest result sits on preset_id, alarm_index and last_fire while empty is
// low and is taken at a rising edge with pop high. Alarms are loaded through
// cfg_wr_en, cfg_index and cfg_wdata; the user must do so only while the block
// is idle, which the block does not enforce. A tick whose minute differs from
// the last one fires every matching alarm, one beat per alarm in index order,
// with last_fire on the final beat; a tick that fires nothing gives no beat.
// A tick's first beat passes the match queue, the back's vector register and its
// output register; results leave one per cycle while pop keeps the output free.
// A tick can be taken every cycle while the four-entry match queue has room.
// When pop stays low the back holds its result and the queue fills, then full
// rises. Reset clears all alarms, empties the queue and forgets the last minute.

module weekly_date_range_alarm_matcher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [wdram_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wdram_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             push,
	output logic                             full,
	input  logic [wdram_pkg::HOUR_W-1:0]     local_hour,
	input  logic [wdram_pkg::MINUTE_W-1:0]   local_minute,
	input  logic [wdram_pkg::WDAY_W-1:0]     day_of_week,
	input  logic [wdram_pkg::DAY_W-1:0]      day_of_month,
	input  logic [wdram_pkg::MONTH_W-1:0]    month_of_year,
	output logic                             empty,
	input  logic                             pop,
	output logic [wdram_pkg::PRESET_W-1:0]   preset_id,
	output logic [wdram_pkg::IDX_W-1:0]      alarm_index,
	output logic                             last_fire
);
	import wdram_pkg::*;

	match_beat_t enq;
	match_vec_t  head;
	q_stat_t     q_stat;
	preset_vec_t presets;
	logic        deq;

	// Front: alarm registers and matching.
	wdram_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.push          (push),
		.q_stat        (q_stat),
		.local_hour    (local_hour),
		.local_minute  (local_minute),
		.day_of_week   (day_of_week),
		.day_of_month  (day_of_month),
		.month_of_year (month_of_year),
		.enq           (enq),
		.presets       (presets)
	);

	// Queue of match vectors.
	wdram_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (enq),
		.deq    (deq),
		.head   (head),
		.stat   (q_stat)
	);

	// Back: result beats.
	wdram_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.presets     (presets),
		.pop         (pop),
		.deq         (deq),
		.empty       (empty),
		.preset_id   (preset_id),
		.alarm_index (alarm_index),
		.last_fire   (last_fire)
	);

	assign full = q_stat.full;

endmodule
